### rtl/aigs_pkg.sv
`timescale 1ns / 1ps

package aigs_pkg;

   // Twister geometry and constants (MT19937-64).
   localparam int TW_N = 312;
   localparam int TW_M = 156;
   localparam int TW_IDX_W = 9;
   localparam logic [63:0] TW_SEED   = 64'h0000_0000_000A_11CE;
   localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
   localparam logic [63:0] TW_MULT   = 64'h5851_F42D_4C95_7F2D;

   localparam int ROUND_W = 6;
   localparam int NODE_W = 12;
   localparam int VAR_W = 10;
   localparam int ROUNDS_REG_W = 7;
   localparam logic [ROUNDS_REG_W-1:0] ROUNDS_RESET = 7'd16;
   localparam logic [ROUNDS_REG_W-1:0] ROUNDS_MAX = 7'd64;
   localparam logic [VAR_W-1:0] COUNT_MAX = 10'd1023;
   localparam logic [VAR_W-1:0] COUNT_STRUCT_LIMIT = 10'd62;

   // Register index of the round count.
   localparam logic REG_ROUNDS = 1'b0;

   typedef enum logic [2:0] {
      KIND_START    = 3'd0,
      KIND_VARIABLE = 3'd1,
      KIND_CONSTANT = 3'd2,
      KIND_LITERAL  = 3'd3,
      KIND_AND      = 3'd4
   } kind_type;

   typedef struct packed {
      logic seed;
      logic draw;
   } tw_ctl_type;

   typedef struct packed {
      logic        busy;
      logic        draw_valid;
      logic [63:0] draw_word;
   } tw_sts_type;

endpackage

### rtl/aigs_twister.sv
`timescale 1ns / 1ps

module aigs_twister
   import aigs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  tw_ctl_type ctl,
   output tw_sts_type sts
);

   typedef enum logic [3:0] {
      TW_SEED_START,
      TW_SEED_M0,
      TW_SEED_M1,
      TW_SEED_M2,
      TW_IDLE,
      TW_RG_START,
      TW_RG_LOAD,
      TW_RG_READ,
      TW_RG_WRITE,
      TW_DRAW_READ,
      TW_DRAW_TEMPER
   } tw_state_type;

   tw_state_type state_ff;
   logic [TW_IDX_W-1:0] idx_ff;
   logic [TW_IDX_W-1:0] pos_ff;
   logic [63:0] prev_ff;
   logic [63:0] acc_ff;
   logic [63:0] cur_ff;
   logic [63:0] word_ff;
   logic        valid_ff;
   logic [63:0] rd_a_ff;
   logic [63:0] rd_b_ff;

   logic [63:0] twister_mem [TW_N];

   logic [63:0] x_in;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [63:0] seed_word;
   logic [63:0] y_in;
   logic [63:0] regen_word;
   logic [63:0] t0, t1, t2, t3;
   logic [TW_IDX_W-1:0] next_idx;
   logic [TW_IDX_W-1:0] mid_idx;
   logic [TW_IDX_W-1:0] addr_a;
   logic                we;
   logic [TW_IDX_W-1:0] waddr;
   logic [63:0]         wdata;

   assign x_in = prev_ff ^ (prev_ff >> 62);

   // One 32x32 multiplier builds the low 64 bits of the seeding product in three passes.
   always_comb begin
      case (state_ff)
         TW_SEED_M1: begin
            mul_a = x_in[63:32];
            mul_b = TW_MULT[31:0];
         end
         TW_SEED_M2: begin
            mul_a = x_in[31:0];
            mul_b = TW_MULT[63:32];
         end
         default: begin
            mul_a = x_in[31:0];
            mul_b = TW_MULT[31:0];
         end
      endcase
   end

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
   assign seed_word = acc_ff + {mul_p[31:0], 32'd0};

   assign next_idx = (idx_ff == TW_IDX_W'(TW_N - 1)) ? '0 : idx_ff + 9'd1;
   assign mid_idx = (idx_ff < TW_IDX_W'(TW_M)) ? idx_ff + TW_IDX_W'(TW_M)
                                               : idx_ff - TW_IDX_W'(TW_M);

   assign y_in = {cur_ff[63:31], rd_a_ff[30:0]};
   assign regen_word = rd_b_ff ^ (y_in >> 1) ^ (y_in[0] ? TW_MATRIX : 64'd0);

   assign t0 = rd_a_ff ^ ((rd_a_ff >> 29) & 64'h5555_5555_5555_5555);
   assign t1 = t0 ^ ((t0 << 17) & 64'h71D6_7FFF_EDA6_0000);
   assign t2 = t1 ^ ((t1 << 37) & 64'hFFF7_EEE0_0000_0000);
   assign t3 = t2 ^ (t2 >> 43);

   always_comb begin
      case (state_ff)
         TW_RG_READ:   addr_a = next_idx;
         TW_DRAW_READ: addr_a = pos_ff;
         default:      addr_a = '0;
      endcase
   end

   always_comb begin
      we = 1'b0;
      waddr = idx_ff;
      wdata = regen_word;
      case (state_ff)
         TW_SEED_START: begin
            we = 1'b1;
            waddr = '0;
            wdata = TW_SEED;
         end
         TW_SEED_M2: begin
            we = 1'b1;
            wdata = seed_word;
         end
         TW_RG_WRITE: begin
            we = 1'b1;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         twister_mem[waddr] <= wdata;
      end
      rd_a_ff <= twister_mem[addr_a];
      rd_b_ff <= twister_mem[mid_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TW_SEED_START;
         pos_ff <= TW_IDX_W'(TW_N);
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            TW_SEED_START: begin
               prev_ff <= TW_SEED;
               idx_ff <= 9'd1;
               state_ff <= TW_SEED_M0;
            end
            TW_SEED_M0: begin
               acc_ff <= mul_p + {55'd0, idx_ff};
               state_ff <= TW_SEED_M1;
            end
            TW_SEED_M1: begin
               acc_ff <= acc_ff + {mul_p[31:0], 32'd0};
               state_ff <= TW_SEED_M2;
            end
            TW_SEED_M2: begin
               prev_ff <= seed_word;
               if (idx_ff == TW_IDX_W'(TW_N - 1)) begin
                  pos_ff <= TW_IDX_W'(TW_N);
                  state_ff <= TW_IDLE;
               end else begin
                  idx_ff <= idx_ff + 9'd1;
                  state_ff <= TW_SEED_M0;
               end
            end
            TW_IDLE: begin
               if (ctl.seed) begin
                  state_ff <= TW_SEED_START;
               end else if (ctl.draw) begin
                  if (pos_ff >= TW_IDX_W'(TW_N)) begin
                     state_ff <= TW_RG_START;
                  end else begin
                     state_ff <= TW_DRAW_READ;
                  end
               end
            end
            TW_RG_START: begin
               state_ff <= TW_RG_LOAD;
            end
            TW_RG_LOAD: begin
               cur_ff <= rd_a_ff;
               idx_ff <= '0;
               state_ff <= TW_RG_READ;
            end
            TW_RG_READ: begin
               state_ff <= TW_RG_WRITE;
            end
            TW_RG_WRITE: begin
               cur_ff <= rd_a_ff;
               if (idx_ff == TW_IDX_W'(TW_N - 1)) begin
                  pos_ff <= '0;
                  state_ff <= TW_DRAW_READ;
               end else begin
                  idx_ff <= idx_ff + 9'd1;
                  state_ff <= TW_RG_READ;
               end
            end
            TW_DRAW_READ: begin
               state_ff <= TW_DRAW_TEMPER;
            end
            TW_DRAW_TEMPER: begin
               word_ff <= t3;
               valid_ff <= 1'b1;
               pos_ff <= pos_ff + 9'd1;
               state_ff <= TW_IDLE;
            end
            default: begin
               state_ff <= TW_IDLE;
            end
         endcase
      end
   end

   assign sts.busy = (state_ff != TW_IDLE);
   assign sts.draw_valid = valid_ff;
   assign sts.draw_word = word_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      ctl.seed |-> state_ff == TW_IDLE)
      else $error("seed requested while twister busy");
   assert property (@(posedge clock) disable iff (reset)
      ctl.draw |-> state_ff == TW_IDLE)
      else $error("draw requested while twister busy");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> $past(state_ff == TW_DRAW_TEMPER) && pos_ff <= TW_IDX_W'(TW_N))
      else $error("draw word without a tempered read");
`endif

endmodule

### rtl/aig_bit_parallel_simulator.sv
`timescale 1ns / 1ps

// Channel  Handshake              Word
// req      req_valid / req_stall  kind, node, variable and fanin slots
// rsp      rsp_valid / rsp_stall  signature word, round, node, last flag
// csr      psel / penable / pwrite  rounds_in_use at byte address 0
//
// A node item passes through a read state and a compute state for each round,
// one round word after another. A variable item makes one twister draw per round;
// the first draw after seeding and every 312th draw after it first regenerate the
// twister table. After reset and after a start item the twister reseeds, and
// req_stall is high while it does. A stalled result word does not block
// acceptance of the next item, but it holds the node sequencer.

module aig_bit_parallel_simulator
   import aigs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_kind,
   input  logic [NODE_W-1:0]       req_node_slot,
   input  logic [VAR_W-1:0]        req_variable_slot,
   input  logic [NODE_W-1:0]       req_left_slot,
   input  logic                    req_left_inverted,
   input  logic [NODE_W-1:0]       req_right_slot,
   input  logic                    req_right_inverted,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [63:0]             rsp_signature_word,
   output logic [ROUND_W-1:0]      rsp_round_number,
   output logic [NODE_W-1:0]       rsp_result_node,
   output logic                    rsp_last_word,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_VDRAW,
      S_VWAIT,
      S_NREAD,
      S_NCALC
   } state_type;

   state_type state_ff;
   logic [ROUNDS_REG_W-1:0] rounds_ff;
   logic [VAR_W-1:0]  count_ff;
   kind_type          kind_ff;
   logic [NODE_W-1:0] node_ff;
   logic [VAR_W-1:0]  var_ff;
   logic [NODE_W-1:0] left_ff;
   logic [NODE_W-1:0] right_ff;
   logic              linv_ff;
   logic              rinv_ff;
   logic [ROUND_W-1:0] round_ff;
   logic [ROUND_W-1:0] last_ff;

   logic               rsp_valid_ff;
   logic [63:0]        rsp_word_ff;
   logic [ROUND_W-1:0] rsp_round_ff;
   logic [NODE_W-1:0]  rsp_node_ff;
   logic               rsp_last_ff;

   logic [63:0] pattern_mem   [2**(VAR_W+ROUND_W)];
   logic [63:0] signature_mem [2**(NODE_W+ROUND_W)];
   logic [63:0] pat_rd_ff;
   logic [63:0] left_rd_ff;
   logic [63:0] right_rd_ff;

   tw_ctl_type tw_ctl;
   tw_sts_type tw_sts;

   logic               req_accept;
   logic               out_free;
   logic [ROUND_W-1:0] eff_last;
   logic [63:0]        structured;
   logic               pat_we;
   logic [63:0]        pat_wdata;
   logic               sig_we;
   logic [63:0]        node_word;

   aigs_twister u_twister (
      .clock(clock),
      .reset(reset),
      .ctl  (tw_ctl),
      .sts  (tw_sts)
   );

   // Configuration port.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_ROUNDS) ? {25'd0, rounds_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_ff <= ROUNDS_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROUNDS) begin
         rounds_ff <= pwdata[ROUNDS_REG_W-1:0];
      end
   end

   // A count of zero runs one round; anything above the maximum runs all of them.
   always_comb begin
      if (rounds_ff == '0) begin
         eff_last = '0;
      end else if (rounds_ff > ROUNDS_MAX) begin
         eff_last = '1;
      end else begin
         eff_last = ROUND_W'(rounds_ff - 7'd1);
      end
   end

   assign req_stall = (state_ff != S_IDLE) || tw_sts.busy;
   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign tw_ctl.seed = req_accept && (kind_type'(req_kind) == KIND_START);
   assign tw_ctl.draw = (state_ff == S_VDRAW);

   always_comb begin
      structured = 64'd2;
      if (count_ff < COUNT_STRUCT_LIMIT) begin
         structured = structured | (64'd1 << (ROUND_W'(count_ff) + 6'd2));
      end
   end

   assign pat_we = (state_ff == S_VWAIT) && tw_sts.draw_valid;
   assign pat_wdata = (round_ff == '0) ? structured : tw_sts.draw_word;

   always_comb begin
      case (kind_ff)
         KIND_CONSTANT: node_word = '1;
         KIND_LITERAL:  node_word = pat_rd_ff;
         KIND_AND:      node_word = (left_rd_ff ^ {64{linv_ff}}) &
                                    (right_rd_ff ^ {64{rinv_ff}});
         default:       node_word = '0;
      endcase
   end

   assign sig_we = (state_ff == S_NCALC) && out_free;

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pattern_mem[{var_ff, round_ff}] <= pat_wdata;
      end
      pat_rd_ff <= pattern_mem[{var_ff, round_ff}];
   end

   always_ff @(posedge clock) begin
      if (sig_we) begin
         signature_mem[{node_ff, round_ff}] <= node_word;
      end
      left_rd_ff <= signature_mem[{left_ff, round_ff}];
      right_rd_ff <= signature_mem[{right_ff, round_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (sig_we) begin
            rsp_valid_ff <= 1'b1;
            rsp_word_ff <= node_word;
            rsp_round_ff <= round_ff;
            rsp_node_ff <= node_ff;
            rsp_last_ff <= (round_ff == last_ff);
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  kind_ff <= kind_type'(req_kind);
                  node_ff <= req_node_slot;
                  var_ff <= req_variable_slot;
                  left_ff <= req_left_slot;
                  right_ff <= req_right_slot;
                  linv_ff <= req_left_inverted;
                  rinv_ff <= req_right_inverted;
                  round_ff <= '0;
                  last_ff <= eff_last;
                  case (kind_type'(req_kind))
                     KIND_START: begin
                        count_ff <= '0;
                     end
                     KIND_VARIABLE: begin
                        state_ff <= S_VDRAW;
                     end
                     KIND_CONSTANT, KIND_LITERAL, KIND_AND: begin
                        state_ff <= S_NREAD;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_VDRAW: begin
               state_ff <= S_VWAIT;
            end
            S_VWAIT: begin
               if (tw_sts.draw_valid) begin
                  if (round_ff == last_ff) begin
                     if (count_ff != COUNT_MAX) begin
                        count_ff <= count_ff + 10'd1;
                     end
                     state_ff <= S_IDLE;
                  end else begin
                     round_ff <= round_ff + 6'd1;
                     state_ff <= S_VDRAW;
                  end
               end
            end
            S_NREAD: begin
               state_ff <= S_NCALC;
            end
            S_NCALC: begin
               if (out_free) begin
                  if (round_ff == last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     round_ff <= round_ff + 6'd1;
                     state_ff <= S_NREAD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_signature_word = rsp_word_ff;
   assign rsp_round_number = rsp_round_ff;
   assign rsp_result_node = rsp_node_ff;
   assign rsp_last_word = rsp_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VWAIT) |-> (tw_sts.busy || tw_sts.draw_valid))
      else $error("waiting for a draw the twister is not making");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_NCALC))
      else $error("result word appeared outside the node sequence");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_word) |-> (rsp_round_number == last_ff))
      else $error("last word flag on the wrong round");
`endif

endmodule

### dv/aig_bit_parallel_simulator_checker.sv
`timescale 1ns / 1ps

module aig_bit_parallel_simulator_checker
   import aigs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [2:0]          req_kind,
   input  logic [NODE_W-1:0]   req_node_slot,
   input  logic [VAR_W-1:0]    req_variable_slot,
   input  logic [NODE_W-1:0]   req_left_slot,
   input  logic                req_left_inverted,
   input  logic [NODE_W-1:0]   req_right_slot,
   input  logic                req_right_inverted,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [63:0]         rsp_signature_word,
   input  logic [ROUND_W-1:0]  rsp_round_number,
   input  logic [NODE_W-1:0]   rsp_result_node,
   input  logic                rsp_last_word,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   input  logic                pready,
   output int                  words_pending,
   output int                  words_checked,
   output int                  failures
);

   localparam int NODES = 4096;
   localparam int VARIABLES = 1024;
   localparam int ROUNDS = 64;
   localparam logic [63:0] TW_UPPER = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] TW_LOWER = 64'h0000_0000_7FFF_FFFF;

   typedef struct {
      logic [63:0]        word;
      logic [ROUND_W-1:0] round_no;
      logic [NODE_W-1:0]  node;
      logic               last;
   } sig_word_type;

   logic [63:0] twister [TW_N];
   int          twister_pos;
   int          var_count;
   logic [ROUNDS_REG_W-1:0] rounds_reg;
   logic [63:0] patterns [VARIABLES][ROUNDS];
   logic [63:0] signatures [NODES][ROUNDS];
   sig_word_type expected_words [$];

   function automatic void twister_seed();
      twister[0] = TW_SEED;
      for (int i = 1; i < TW_N; i++)
         twister[i] = TW_MULT * (twister[i-1] ^ (twister[i-1] >> 62)) + 64'(i);
      twister_pos = TW_N;
   endfunction

   function automatic logic [63:0] twister_draw();
      logic [63:0] x;
      logic [63:0] y;
      if (twister_pos >= TW_N) begin
         for (int i = 0; i < TW_N; i++) begin
            y = (twister[i] & TW_UPPER) | (twister[(i + 1) % TW_N] & TW_LOWER);
            x = twister[(i + TW_M) % TW_N] ^ (y >> 1);
            if (y[0]) x ^= TW_MATRIX;
            twister[i] = x;
         end
         twister_pos = 0;
      end
      x = twister[twister_pos];
      twister_pos++;
      x ^= (x >> 29) & 64'h5555_5555_5555_5555;
      x ^= (x << 17) & 64'h71D6_7FFF_EDA6_0000;
      x ^= (x << 37) & 64'hFFF7_EEE0_0000_0000;
      x ^= x >> 43;
      return x;
   endfunction

   function automatic int active_rounds();
      if (rounds_reg < 1) return 1;
      if (rounds_reg > ROUNDS_MAX) return int'(ROUNDS_MAX);
      return int'(rounds_reg);
   endfunction

   function automatic void predict_item();
      int          r;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] w;
      sig_word_type e;
      r = active_rounds();
      case (req_kind)
         KIND_START: begin
            twister_seed();
            var_count = 0;
         end
         KIND_VARIABLE: begin
            for (int i = 0; i < r; i++) patterns[req_variable_slot][i] = twister_draw();
            w = 64'd2;
            if (var_count < 62) w[var_count + 2] = 1'b1;
            patterns[req_variable_slot][0] = w;
            if (var_count < int'(COUNT_MAX)) var_count++;
         end
         KIND_CONSTANT, KIND_LITERAL, KIND_AND: begin
            for (int i = 0; i < r; i++) begin
               if (req_kind == KIND_CONSTANT) begin
                  w = '1;
               end else if (req_kind == KIND_LITERAL) begin
                  w = patterns[req_variable_slot][i];
               end else begin
                  a = signatures[req_left_slot][i];
                  b = signatures[req_right_slot][i];
                  if (req_left_inverted) a = ~a;
                  if (req_right_inverted) b = ~b;
                  w = a & b;
               end
               signatures[req_node_slot][i] = w;
               e.word = w;
               e.round_no = ROUND_W'(i);
               e.node = req_node_slot;
               e.last = (i == r - 1);
               expected_words = {expected_words, e};
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_word();
      sig_word_type e;
      words_checked++;
      if (expected_words.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected word: node %0d round %0d word %h",
                     rsp_result_node, rsp_round_number, rsp_signature_word);
         return;
      end
      e = expected_words.pop_front();
      if (rsp_signature_word !== e.word || rsp_round_number !== e.round_no ||
          rsp_result_node !== e.node || rsp_last_word !== e.last) begin
         failures++;
         if (failures <= 10)
            $display("mismatch: expected node %0d round %0d last %0b word %h, got node %0d round %0d last %0b word %h",
                     e.node, e.round_no, e.last, e.word, rsp_result_node,
                     rsp_round_number, rsp_last_word, rsp_signature_word);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         twister_seed();
         var_count = 0;
         rounds_reg = ROUNDS_RESET;
         expected_words.delete();
         words_checked = 0;
         failures = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_ROUNDS))
            rounds_reg = pwdata[ROUNDS_REG_W-1:0];
         if (req_valid && !req_stall) predict_item();
         if (rsp_valid && !rsp_stall) compare_word();
      end
      words_pending = expected_words.size();
   end

endmodule

### dv/aig_bit_parallel_simulator_test.sv
`timescale 1ns / 1ps

module aig_bit_parallel_simulator_test;
   import aigs_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE = 2500;
   localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
   localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_kind = KIND_START;
   logic [NODE_W-1:0]   req_node_slot = '0;
   logic [VAR_W-1:0]    req_variable_slot = '0;
   logic [NODE_W-1:0]   req_left_slot = '0;
   logic                req_left_inverted = 1'b0;
   logic [NODE_W-1:0]   req_right_slot = '0;
   logic                req_right_inverted = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [63:0]         rsp_signature_word;
   logic [ROUND_W-1:0]  rsp_round_number;
   logic [NODE_W-1:0]   rsp_result_node;
   logic                rsp_last_word;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [2:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   int words_pending;
   int words_checked;
   int failures;
   int cycles = 0;
   int items_sent = 0;
   int settings_used = 0;
   int rounds_now = 16;
   bit quiet_req = 0;
   bit quiet_rsp = 0;
   int stall_left = 0;
   // Rounds written so far per variable and per node; a read never goes past them.
   int var_rounds [1024];
   int node_rounds [4096];
   int written_nodes [$];
   int declared_vars [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   aig_bit_parallel_simulator dut (.*);

   aig_bit_parallel_simulator_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side stall: a fresh hold-off is drawn for each accepted word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         int n;
         if ($urandom_range(0, 99) < 3) quiet_rsp <= ~quiet_rsp;
         n = quiet_rsp ? 0 : $urandom_range(0, 11);
         rsp_stall <= (n > 0);
         stall_left <= (n > 0) ? n - 1 : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(logic [2:0] kind, int node, int var_slot,
                            int lslot, bit linv, int rslot, bit rinv);
      int gap;
      if ($urandom_range(0, 99) < 4) quiet_req = ~quiet_req;
      gap = quiet_req ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_node_slot <= NODE_W'(node);
      req_variable_slot <= VAR_W'(var_slot);
      req_left_slot <= NODE_W'(lslot);
      req_left_inverted <= linv;
      req_right_slot <= NODE_W'(rslot);
      req_right_inverted <= rinv;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (kind == KIND_VARIABLE) begin
         if (var_rounds[var_slot] < rounds_now) var_rounds[var_slot] = rounds_now;
         declared_vars = {declared_vars, var_slot};
      end else if (kind == KIND_CONSTANT || kind == KIND_LITERAL || kind == KIND_AND) begin
         if (node_rounds[node] < rounds_now) node_rounds[node] = rounds_now;
         written_nodes = {written_nodes, node};
      end
   endtask

   task automatic set_rounds(int value);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (words_pending == 0);
      repeat (SETTLE) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 3'(4 * REG_ROUNDS);
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      rounds_now = (value < 1) ? 1 : (value > 64) ? 64 : value;
      settings_used++;
   endtask

   // Picks a slot whose stored rounds cover the current setting, or -1.
   function automatic int pick_node();
      int n;
      for (int t = 0; t < 12 && written_nodes.size() > 0; t++) begin
         n = written_nodes[$urandom_range(0, written_nodes.size() - 1)];
         if (node_rounds[n] >= rounds_now) return n;
      end
      return -1;
   endfunction

   function automatic int pick_var();
      int v;
      for (int t = 0; t < 12 && declared_vars.size() > 0; t++) begin
         v = declared_vars[$urandom_range(0, declared_vars.size() - 1)];
         if (var_rounds[v] >= rounds_now) return v;
      end
      return -1;
   endfunction

   task automatic random_item();
      int sel;
      int a;
      int b;
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
         send_item(KIND_START, $urandom_range(0, 4095), $urandom_range(0, 1023),
                   $urandom_range(0, 4095), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
      end else if (sel < 30) begin
         send_item(KIND_VARIABLE, $urandom_range(0, 4095), $urandom_range(0, 1023),
                   0, 0, 0, 0);
      end else if (sel < 40) begin
         send_item(KIND_CONSTANT, $urandom_range(0, 4095), 0, 0, 0, 0, 0);
      end else if (sel < 62) begin
         a = pick_var();
         if (a < 0) send_item(KIND_VARIABLE, 0, $urandom_range(0, 1023), 0, 0, 0, 0);
         else send_item(KIND_LITERAL, $urandom_range(0, 4095), a, 0, 0, 0, 0);
      end else if (sel < 95) begin
         a = pick_node();
         b = pick_node();
         if (a < 0 || b < 0)
            send_item(KIND_CONSTANT, $urandom_range(0, 4095), 0, 0, 0, 0, 0);
         else
            send_item(KIND_AND, $urandom_range(0, 4095), $urandom_range(0, 1023),
                      a, 1'($urandom_range(0, 1)), b, 1'($urandom_range(0, 1)));
      end else begin
         send_item(3'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI)),
                   $urandom_range(0, 4095), $urandom_range(0, 1023),
                   $urandom_range(0, 4095), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int settings [6];
      foreach (var_rounds[i]) var_rounds[i] = 0;
      foreach (node_rounds[i]) node_rounds[i] = 0;
      settings = '{1, 64, 0, 127, 0, 16};
      settings[4] = $urandom_range(2, 63);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset round count.
      send_item(KIND_START, 0, 0, 0, 0, 0, 0);
      send_item(KIND_VARIABLE, 0, 0, 0, 0, 0, 0);
      send_item(KIND_VARIABLE, 0, 1023, 0, 0, 0, 0);
      send_item(KIND_VARIABLE, 0, 5, 0, 0, 0, 0);
      send_item(KIND_CONSTANT, 4095, 0, 0, 0, 0, 0);
      send_item(KIND_CONSTANT, 0, 0, 0, 0, 0, 0);
      send_item(KIND_LITERAL, 1, 1023, 0, 0, 0, 0);
      send_item(KIND_LITERAL, 2, 0, 0, 0, 0, 0);
      send_item(KIND_AND, 3, 0, 1, 0, 2, 0);
      send_item(KIND_AND, 4, 0, 1, 1, 2, 0);
      send_item(KIND_AND, 5, 0, 4095, 0, 2, 1);
      send_item(KIND_AND, 4095, 1023, 1, 1, 4095, 1);
      send_item(KIND_AND, 6, 0, 0, 0, 0, 1);
      send_item(3'd5, 4095, 1023, 4095, 1, 4095, 1);
      send_item(3'd6, 0, 0, 0, 0, 0, 0);
      send_item(KIND_RESERVED_HI, 7, 7, 7, 1, 7, 0);
      send_item(KIND_START, 4095, 1023, 4095, 1, 4095, 1);
      send_item(KIND_VARIABLE, 0, 5, 0, 0, 0, 0);
      send_item(KIND_LITERAL, 7, 5, 0, 0, 0, 0);

      // Declare enough variables at one round to pass the structured bit limit.
      set_rounds(1);
      send_item(KIND_START, 0, 0, 0, 0, 0, 0);
      repeat (70) send_item(KIND_VARIABLE, 0, $urandom_range(0, 1023), 0, 0, 0, 0);
      send_item(KIND_LITERAL, 8, declared_vars[$], 0, 0, 0, 0);

      foreach (settings[s]) begin
         set_rounds(settings[s]);
         repeat (30) random_item();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (words_pending == 0);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d items over %0d round settings, past the structured bit limit.",
               items_sent, settings_used);
      $display("Checked %0d signature words, %0d mismatches.", words_checked, failures);
      if (failures == 0 && words_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
